// ===== src/asi_pkg.sv =====
// shared constants for the arm safety interlock: stream layout, item kinds and state codes
`default_nettype none
package asi_pkg;

	// input stream layout
	localparam int IN_TDATA_W  = 8;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 8;

	// input tdata bit positions
	localparam int B_REMOTE_LINK_UP = 0;
	localparam int B_ARM_SWITCH_UP  = 1;
	localparam int B_SETTINGS_OK    = 2;
	localparam int B_MOTORS_PRESENT = 3;
	localparam int B_BUS_OK         = 4;

	// output tdata layout
	localparam int GATE_STATE_W     = 3;
	localparam int B_DRIVE_ENABLE   = 3;

	// item kinds carried in s_axis_tuser
	localparam logic [IN_TUSER_W-1:0] ACT_SAMPLE = 1'b0;
	localparam logic [IN_TUSER_W-1:0] ACT_CLEAR  = 1'b1;

	// gate state codes as seen on the output
	localparam logic [GATE_STATE_W-1:0] GATE_DISABLED    = 3'd0;
	localparam logic [GATE_STATE_W-1:0] GATE_WAIT_REMOTE = 3'd1;
	localparam logic [GATE_STATE_W-1:0] GATE_WAIT_MOTORS = 3'd2;
	localparam logic [GATE_STATE_W-1:0] GATE_ARMED       = 3'd3;
	localparam logic [GATE_STATE_W-1:0] GATE_FAULT       = 3'd4;

endpackage
`default_nettype wire

// ===== src/arm_safety_interlock_fsm_top.sv =====
// arm safety interlock: input register, interlock state machine and result register
//
// Each accepted item is either a health/switch sample or a fault-clear request
// (s_axis_tuser) and yields exactly one result item carrying the gate state after
// that item and the drive enable flag. The block takes one item per clock cycle
// when the output side keeps up; an accepted item is held in the input register and
// then its result in the result register. The interlock state and switch history
// update as an item leaves the input register, so each item sees the state left
// by the one before it.
// s_axis_tready falls only while both registers hold items and m_axis_tready is low.
`default_nettype none
module arm_safety_interlock_fsm_top (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// [0] remote_link_up, [1] arm_switch_up, [2] settings_ok, [3] motors_present,
	// [4] bus_ok, [7:5] zero
	input  wire  [asi_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// [0] action: 0 sample update, 1 fault-clear request
	input  wire  [asi_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// [2:0] gate_state, [3] drive_enable, [7:4] zero
	output logic [asi_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import asi_pkg::*;

	typedef enum logic [GATE_STATE_W-1:0] {
		ST_DISABLED    = GATE_DISABLED,
		ST_WAIT_REMOTE = GATE_WAIT_REMOTE,
		ST_WAIT_MOTORS = GATE_WAIT_MOTORS,
		ST_ARMED       = GATE_ARMED,
		ST_FAULT       = GATE_FAULT
	} mode_t;

	logic                    valid_s1;
	logic [IN_TDATA_W-1:0]   data_s1;
	logic [IN_TUSER_W-1:0]   action_s1;
	logic                    valid_s2;
	mode_t                   gate_s2;
	logic                    drive_s2;

	mode_t mode_q, mode_d;
	logic  last_sw_q, last_sw_d;
	logic  release_seen_q, release_seen_d;
	logic  fault_rel_q, fault_rel_d;

	logic adv;
	logic online, sw, cfg_ok, motors, bus, rising;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	assign online = data_s1[B_REMOTE_LINK_UP];
	assign sw     = data_s1[B_ARM_SWITCH_UP];
	assign cfg_ok = data_s1[B_SETTINGS_OK];
	assign motors = data_s1[B_MOTORS_PRESENT];
	assign bus    = data_s1[B_BUS_OK];
	assign rising = online && sw && !last_sw_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1   <= s_axis_tdata;
			action_s1 <= s_axis_tuser;
		end
	end

	// next interlock state for the item in the input register
	always_comb begin
		mode_d         = mode_q;
		last_sw_d      = last_sw_q;
		release_seen_d = release_seen_q;
		fault_rel_d    = fault_rel_q;
		if (action_s1 == ACT_CLEAR) begin
			if (mode_q == ST_FAULT && fault_rel_q) begin
				mode_d      = ST_DISABLED;
				fault_rel_d = 1'b0;
			end
		end else begin
			if (online && !sw) begin
				release_seen_d = 1'b1;
				if (mode_q == ST_FAULT) begin
					fault_rel_d = 1'b1;
				end
			end
			unique case (mode_q)
				ST_FAULT: begin
					mode_d = ST_FAULT;
				end
				ST_ARMED: begin
					if (!cfg_ok || !online || !motors || !bus) begin
						mode_d      = ST_FAULT;
						fault_rel_d = online && !sw;
					end else if (!sw) begin
						mode_d = ST_DISABLED;
					end
				end
				default: begin
					if (!cfg_ok) begin
						mode_d = ST_DISABLED;
					end else if (!online) begin
						mode_d = ST_WAIT_REMOTE;
					end else if (!motors || !bus) begin
						mode_d = ST_WAIT_MOTORS;
					end else if (release_seen_d && rising) begin
						mode_d = ST_ARMED;
					end else begin
						mode_d = ST_DISABLED;
					end
				end
			endcase
			if (online) begin
				last_sw_d = sw;
			end
		end
	end

	// interlock state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= ST_DISABLED;
			last_sw_q      <= 1'b0;
			release_seen_q <= 1'b0;
			fault_rel_q    <= 1'b0;
			valid_s2       <= 1'b0;
			gate_s2        <= ST_DISABLED;
			drive_s2       <= 1'b0;
		end else begin
			if (adv) begin
				mode_q         <= mode_d;
				last_sw_q      <= last_sw_d;
				release_seen_q <= release_seen_d;
				fault_rel_q    <= fault_rel_d;
				gate_s2        <= mode_d;
				drive_s2       <= (mode_d == ST_ARMED);
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = valid_s2;
	always_comb begin
		m_axis_tdata                     = '0;
		m_axis_tdata[GATE_STATE_W-1:0]   = gate_s2;
		m_axis_tdata[B_DRIVE_ENABLE]     = drive_s2;
	end

	// drive enable goes with the armed state only
	a_drive_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[B_DRIVE_ENABLE] == (gate_s2 == ST_ARMED)))
		else $error("drive_enable does not match gate state");

	// a sample never leaves the fault latch
	a_fault_holds_on_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && mode_q == ST_FAULT && action_s1 == ACT_SAMPLE) |=> (mode_q == ST_FAULT))
		else $error("fault latch left on a sample item");

	// arming never comes straight out of the fault latch
	a_no_arm_from_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && mode_q == ST_FAULT) |=> (mode_q != ST_ARMED))
		else $error("armed directly from fault");

	// the result carries the state that the item left behind
	a_result_is_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (m_axis_tvalid && m_axis_tdata[GATE_STATE_W-1:0] == mode_q))
		else $error("result state differs from interlock state");

	// release history is sticky
	a_release_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		release_seen_q |=> release_seen_q)
		else $error("release history cleared");

endmodule
`default_nettype wire

// ===== tb/arm_safety_interlock_fsm_top_tb.sv =====
// self-checking testbench for the arm safety interlock with a scoreboard and random stream stalls
`default_nettype none
module arm_safety_interlock_fsm_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import asi_pkg::*;

	localparam int RANDOM_ITEMS   = 1750;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int DRAIN_CYCLES   = 10;

	typedef struct packed {
		logic [GATE_STATE_W-1:0] gate_state;
		logic                    drive_enable;
	} gate_result_t;

	class interlock_scoreboard;
		logic [GATE_STATE_W-1:0] mode;
		bit last_switch;
		bit release_latch;
		bit fault_release;
		gate_result_t expected_gates[$];
		int errors;
		int items_in;
		int results_out;
		int state_hits[8];

		function void note_item(logic [IN_TUSER_W-1:0] kind, logic [IN_TDATA_W-1:0] data);
			bit online, sw, cfg, motors, bus, rising;
			gate_result_t res;
			items_in++;
			if (kind == ACT_CLEAR) begin
				if (mode == GATE_FAULT && fault_release) begin
					mode = GATE_DISABLED;
					fault_release = 0;
				end
			end else begin
				online = data[B_REMOTE_LINK_UP];
				sw     = data[B_ARM_SWITCH_UP];
				cfg    = data[B_SETTINGS_OK];
				motors = data[B_MOTORS_PRESENT];
				bus    = data[B_BUS_OK];
				rising = online && sw && !last_switch;
				if (online && !sw) begin
					release_latch = 1;
					if (mode == GATE_FAULT)
						fault_release = 1;
				end
				case (mode)
					GATE_FAULT: begin
						// latched: only the switch history moves
					end
					GATE_ARMED: begin
						if (!cfg || !online || !motors || !bus) begin
							mode = GATE_FAULT;
							fault_release = online && !sw;
						end else if (!sw) begin
							mode = GATE_DISABLED;
						end
					end
					default: begin
						if (!cfg)
							mode = GATE_DISABLED;
						else if (!online)
							mode = GATE_WAIT_REMOTE;
						else if (!motors || !bus)
							mode = GATE_WAIT_MOTORS;
						else if (release_latch && rising)
							mode = GATE_ARMED;
						else
							mode = GATE_DISABLED;
					end
				endcase
				if (online)
					last_switch = sw;
			end
			res.gate_state   = mode;
			res.drive_enable = (mode == GATE_ARMED);
			expected_gates.push_back(res);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] data);
			gate_result_t exp_res;
			logic [GATE_STATE_W-1:0] got_state;
			logic got_enable;
			got_state  = data[GATE_STATE_W-1:0];
			got_enable = data[B_DRIVE_ENABLE];
			results_out++;
			if (expected_gates.size() == 0) begin
				$error("unexpected result item: gate_state %0d, drive_enable %0d",
					got_state, got_enable);
				errors++;
				return;
			end
			exp_res = expected_gates.pop_front();
			state_hits[exp_res.gate_state]++;
			if (got_state !== exp_res.gate_state) begin
				$error("gate_state mismatch: expected %0d, actual %0d",
					exp_res.gate_state, got_state);
				errors++;
			end
			if (got_enable !== exp_res.drive_enable) begin
				$error("drive_enable mismatch: expected %0d, actual %0d",
					exp_res.drive_enable, got_enable);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = ACT_SAMPLE;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	interlock_scoreboard sb = new();
	int send_burst = 0;
	int recv_burst = 0;
	int random_sent = 0;
	int idle_cycles = 0;

	arm_safety_interlock_fsm_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly random waits, with stretches of back-to-back items
	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	function automatic logic [4:0] sample_bits(bit online, bit sw, bit cfg, bit motors, bit bus);
		logic [4:0] v;
		v = '0;
		v[B_REMOTE_LINK_UP] = online;
		v[B_ARM_SWITCH_UP]  = sw;
		v[B_SETTINGS_OK]    = cfg;
		v[B_MOTORS_PRESENT] = motors;
		v[B_BUS_OK]         = bus;
		return v;
	endfunction

	task automatic send_item(input logic [IN_TUSER_W-1:0] kind, input logic [4:0] bits);
		int gap;
		gap = draw_wait(send_burst);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {3'b000, bits};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(kind, {3'b000, bits});
	endtask

	task automatic send_sample(input bit online, input bit sw, input bit cfg,
		input bit motors, input bit bus);
		send_item(ACT_SAMPLE, sample_bits(online, sw, cfg, motors, bus));
	endtask

	// sample fields of a clear request carry random junk
	task automatic send_clear();
		send_item(ACT_CLEAR, 5'($urandom));
	endtask

	task automatic send_noise();
		bit clear;
		clear = ($urandom_range(0, 7) == 0);
		if (clear)
			send_clear();
		else if ($urandom_range(0, 3) == 0)
			send_item(ACT_SAMPLE, 5'($urandom));
		else
			send_sample($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
				$urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
				$urandom_range(0, 7) != 0);
		random_sent++;
	endtask

	// release, arm edge, some armed time, then disarm or fault and a clear attempt
	task automatic arm_sequence();
		int n;
		logic [4:0] bad;
		send_sample(1, 0, 1, 1, 1);
		send_sample(1, 1, 1, 1, 1);
		random_sent += 2;
		n = $urandom_range(0, 4);
		repeat (n) begin
			send_sample(1, 1, 1, 1, 1);
			random_sent++;
		end
		if ($urandom_range(0, 2) == 0) begin
			send_sample(1, 0, 1'($urandom_range(0, 1)), 1, 1);
			random_sent++;
		end else begin
			do bad = 5'($urandom);
			while (bad[B_SETTINGS_OK] && bad[B_REMOTE_LINK_UP] &&
				bad[B_MOTORS_PRESENT] && bad[B_BUS_OK]);
			send_item(ACT_SAMPLE, bad);
			random_sent++;
			n = $urandom_range(0, 3);
			repeat (n) begin
				if ($urandom_range(0, 1) == 0)
					send_clear();
				else
					send_item(ACT_SAMPLE, 5'($urandom));
				random_sent++;
			end
			if ($urandom_range(0, 4) != 0) begin
				send_sample(1, 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				random_sent++;
			end
			send_clear();
			random_sent++;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: health priority, arming rules and fault latch/clear
		send_sample(1, 1, 1, 1, 1);   // edge without an earlier release
		send_clear();                 // clear with nothing latched
		send_sample(1, 0, 0, 1, 1);   // configuration fault
		send_sample(0, 1, 1, 1, 1);   // remote offline
		send_sample(1, 1, 1, 0, 1);   // motors missing
		send_sample(1, 1, 1, 1, 0);   // bus fault
		send_sample(1, 0, 1, 1, 1);   // release
		send_sample(1, 1, 1, 1, 1);   // arm
		send_sample(1, 1, 1, 1, 1);   // hold armed
		send_sample(1, 0, 1, 1, 1);   // release disarms
		send_sample(1, 1, 1, 1, 1);   // re-arm
		send_sample(1, 1, 1, 1, 0);   // bus loss latches fault, no release
		send_clear();                 // refused
		send_sample(0, 0, 1, 1, 1);   // offline release does not count
		send_clear();
		send_sample(1, 0, 0, 0, 0);   // valid release while latched
		send_clear();                 // accepted
		send_sample(1, 1, 1, 1, 1);
		send_sample(0, 0, 1, 1, 1);   // remote loss while armed
		send_clear();
		send_sample(1, 1, 1, 1, 1);
		send_sample(1, 0, 1, 1, 1);
		send_clear();
		send_sample(1, 1, 1, 1, 1);
		send_sample(1, 0, 0, 1, 1);   // fault entered with the switch released
		send_clear();

		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 6)
				arm_sequence();
			else
				send_noise();
		end
		s_axis_tvalid <= 1'b0;

		while (sb.expected_gates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items, checked %0d results", sb.items_in, sb.results_out);
		$display("states: disabled %0d, wait remote %0d, wait motors %0d, armed %0d, fault %0d",
			sb.state_hits[GATE_DISABLED], sb.state_hits[GATE_WAIT_REMOTE],
			sb.state_hits[GATE_WAIT_MOTORS], sb.state_hits[GATE_ARMED],
			sb.state_hits[GATE_FAULT]);
		if (sb.errors == 0 && sb.expected_gates.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = draw_wait(recv_burst);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata);
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
`default_nettype wire

// ===== files.f =====
src/asi_pkg.sv
src/arm_safety_interlock_fsm_top.sv
tb/arm_safety_interlock_fsm_top_tb.sv
